// ===== sv/dwsj_pkg.sv =====
// shared constants, widths and controller/datapath command types for the
// delay window statistics block; no dependencies
`timescale 1ns / 1ps

package dwsj_pkg;

    // window geometry
    localparam int WINDOW = 16;
    localparam int POS_W  = $clog2(WINDOW);

    // timestamp and delay widths
    localparam int SEC_W   = 32;
    localparam int NSEC_W  = 30;
    localparam int DELAY_W = 30;
    localparam int VAR_W   = 59;

    // seconds to microseconds, nanoseconds to microseconds by reciprocal
    localparam int US_PER_SEC = 1000000;
    localparam int US_W       = 21;
    localparam int NS_RECIP   = 1099511628;
    localparam int RECIP_W    = 31;
    localparam int NS_SHIFT   = 40;
    localparam int NSQ_W      = 21;

    // running sums
    localparam int SUM_W = DELAY_W + $clog2(WINDOW);
    localparam int SQ_W  = 2 * DELAY_W - 1;
    localparam int SSQ_W = SQ_W + $clog2(WINDOW);

    // jitter smoothing
    localparam int JIT_SHIFT = 4;

    // constant divider: radix-16 digits, several digits per cycle
    localparam int DIGIT_W    = 4;
    localparam int DIGITS_CYC = 4;
    localparam int CHUNK_W    = DIGIT_W * DIGITS_CYC;
    localparam int DIV_W      = ((2 * SUM_W + CHUNK_W - 1) / CHUNK_W) * CHUNK_W;
    localparam int DIV_CHUNKS = DIV_W / CHUNK_W;
    localparam int DIV_CNT_W  = $clog2(DIV_CHUNKS + 1);
    localparam int REM_W      = $clog2(WINDOW);
    localparam int CUR_W      = REM_W + DIGIT_W;

    // divider passes
    localparam logic [1:0] OP_MEAN = 2'd0;
    localparam logic [1:0] OP_CORR = 2'd1;
    localparam logic [1:0] OP_VAR  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       dly;
        logic       upd;
        logic       acc;
        logic       sq;
        logic       div_start;
        logic       div_take;
        logic       out_load;
        logic [1:0] op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

endpackage

// ===== sv/dwsj_ram.sv =====
// generic single-port-write, registered-read memory
// no dependencies
`timescale 1ns / 1ps

module dwsj_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dwsj_cdiv.sv =====
// iterative divider by the window size or the window size minus one,
// radix-16 long division, several digits per cycle; uses dwsj_pkg
`timescale 1ns / 1ps

module dwsj_cdiv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_by_w1,
    input  logic [dwsj_pkg::DIV_W-1:0] i_num,
    output logic                       o_done,
    output logic [dwsj_pkg::DIV_W-1:0] o_quo
);

    localparam int DW    = dwsj_pkg::DIV_W;
    localparam int GW    = dwsj_pkg::DIGIT_W;
    localparam int RW    = dwsj_pkg::REM_W;
    localparam int CW    = dwsj_pkg::CUR_W;
    localparam int NW    = dwsj_pkg::DIV_CNT_W;
    localparam int RADIX = 2 ** dwsj_pkg::DIGIT_W;

    // one quotient digit: compare against every multiple of the divisor
    function automatic logic [GW+RW-1:0] div_digit(input logic [CW-1:0] cur,
                                                    input logic by_w1);
        logic [GW-1:0] qd;
        logic [CW-1:0] rem;
        logic [15:0]   cur_ext;
        logic [15:0]   mult;
        qd      = '0;
        rem     = cur;
        cur_ext = 16'(cur);
        for (int k = 1; k < RADIX; k++) begin
            mult = by_w1 ? 16'(k * (dwsj_pkg::WINDOW - 1)) : 16'(k * dwsj_pkg::WINDOW);
            if (cur_ext >= mult) begin
                qd  = GW'(k);
                rem = CW'(cur_ext - mult);
            end
        end
        return {qd, rem[RW-1:0]};
    endfunction

    logic [DW-1:0] r_nq, n_nq;
    logic [RW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_cnt, n_cnt;
    logic          r_done, n_done;
    logic          r_by_w1;

    // shift register holds the numerator on top and grows the quotient below
    always_comb begin
        logic [GW+RW-1:0] step;
        logic [DW-1:0]    nq;
        logic [RW-1:0]    rem;
        nq   = r_nq;
        rem  = r_rem;
        step = '0;
        for (int i = 0; i < dwsj_pkg::DIGITS_CYC; i++) begin
            step = div_digit({rem, nq[DW-1 -: GW]}, r_by_w1);
            nq   = {nq[DW-GW-1:0], step[GW+RW-1:RW]};
            rem  = step[RW-1:0];
        end
        n_nq   = r_nq;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_nq  = i_num;
            n_rem = '0;
            n_cnt = NW'(dwsj_pkg::DIV_CHUNKS);
        end else if (r_cnt != '0) begin
            n_nq   = nq;
            n_rem  = rem;
            n_cnt  = r_cnt - NW'(1);
            n_done = (r_cnt == NW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_nq  <= n_nq;
        r_rem <= n_rem;
        if (i_start) begin
            r_by_w1 <= i_by_w1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_nq;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_cnt == '0 && !r_done))
        else $error("divider started while busy");
`endif

endmodule

// ===== sv/dwsj_dp.sv =====
// datapath: delay formation, window memory, running sums, jitter and the
// shared constant divider; uses dwsj_pkg, dwsj_ram, dwsj_cdiv
`timescale 1ns / 1ps

module dwsj_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dwsj_pkg::t_cmd                 i_cmd,
    output dwsj_pkg::t_stat                o_stat,
    input  logic [dwsj_pkg::SEC_W-1:0]     i_arrival_sec,
    input  logic [dwsj_pkg::NSEC_W-1:0]    i_arrival_nsec,
    input  logic [dwsj_pkg::SEC_W-1:0]     i_origin_sec,
    input  logic [dwsj_pkg::NSEC_W-1:0]    i_origin_nsec,
    output logic signed [dwsj_pkg::DELAY_W-1:0] o_delay_us,
    output logic signed [dwsj_pkg::DELAY_W-1:0] o_mean_us,
    output logic [dwsj_pkg::VAR_W-1:0]     o_variance_us,
    output logic [dwsj_pkg::DELAY_W-1:0]   o_jitter_us
);

    localparam int DW    = dwsj_pkg::DELAY_W;
    localparam int SW    = dwsj_pkg::SUM_W;
    localparam int QW    = dwsj_pkg::SQ_W;
    localparam int SSW   = dwsj_pkg::SSQ_W;
    localparam int VW    = dwsj_pkg::VAR_W;
    localparam int XW    = dwsj_pkg::DIV_W;
    localparam int PW    = dwsj_pkg::POS_W;
    localparam int DSW   = dwsj_pkg::SEC_W + 1;
    localparam int DNW   = dwsj_pkg::NSEC_W + 1;
    localparam int PSW   = DSW + dwsj_pkg::US_W;
    localparam int PNW   = dwsj_pkg::NSEC_W + dwsj_pkg::RECIP_W;
    localparam int RAW_W = PSW + 1;
    localparam int HL    = (SW + 1) / 2;
    localparam int HH    = SW - HL;
    localparam int JW    = DW + 2;

    localparam logic signed [RAW_W-1:0] RAW_MAX = RAW_W'(2 ** (DW - 1) - 1);
    localparam logic signed [RAW_W-1:0] RAW_MIN = -RAW_MAX - RAW_W'(1);

    // captured item
    logic [dwsj_pkg::SEC_W-1:0]  r_a_sec, r_o_sec;
    logic [dwsj_pkg::NSEC_W-1:0] r_a_nsec, r_o_nsec;

    // delay pipeline
    logic signed [PSW-1:0] r_p_sec;
    logic [PNW-1:0]        r_p_ns;
    logic                  r_ns_neg;
    logic signed [DW-1:0]  r_oldest;
    logic signed [DW-1:0]  r_delay;

    // window state
    logic [PW-1:0]                 r_pos;
    logic [dwsj_pkg::WINDOW-1:0]   r_vld;
    logic signed [SW-1:0]          r_sum;
    logic [SSW-1:0]                r_ssq;
    logic [QW-1:0]                 r_d2, r_o2;
    logic signed [DW-1:0]          r_prev;
    logic [DW-1:0]                 r_jmag;
    logic [DW-1:0]                 r_jit;

    // statistics
    logic [SW-1:0]       r_abs_sum;
    logic                r_sum_neg;
    logic [2*HH-1:0]     r_pp_hh;
    logic [HH+HL-1:0]    r_pp_hl;
    logic [2*HL-1:0]     r_pp_ll;
    logic [XW-1:0]       r_sq;
    logic [SSW-1:0]      r_var_num;
    logic [DW-1:0]       r_mean;
    logic [VW-1:0]       r_var;

    // output register
    logic signed [DW-1:0] r_out_delay, r_out_mean;
    logic [VW-1:0]        r_out_var;
    logic [DW-1:0]        r_out_jit;

    logic [DW-1:0]  ram_rdata;
    logic           div_done;
    logic [XW-1:0]  div_quo;
    logic [XW-1:0]  div_num;

    logic signed [DSW-1:0]   dsec;
    logic signed [DNW-1:0]   dnsec;
    logic [dwsj_pkg::NSEC_W-1:0] dnsec_mag;
    logic signed [RAW_W-1:0] raw_delay;
    logic signed [RAW_W-1:0] ns_part;
    logic signed [DW-1:0]    sat_delay;
    logic signed [DW:0]      jdiff;
    logic [SW-1:0]           sum_mag;
    logic signed [JW-1:0]    jt, jadj, jnew;
    logic [PW-1:0]           pos_next;

    dwsj_ram #(
        .WIDTH (DW),
        .DEPTH (dwsj_pkg::WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd),
        .i_waddr (r_pos),
        .i_wdata (r_delay),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        unique case (i_cmd.op)
            dwsj_pkg::OP_MEAN: div_num = XW'(r_abs_sum);
            dwsj_pkg::OP_CORR: div_num = r_sq;
            dwsj_pkg::OP_VAR:  div_num = XW'(r_var_num);
            default:           div_num = '0;
        endcase
    end

    dwsj_cdiv u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_by_w1 (i_cmd.op == dwsj_pkg::OP_VAR),
        .i_num   (div_num),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_stat.div_done = div_done;

    always_comb begin
        dsec      = $signed({1'b0, r_a_sec}) - $signed({1'b0, r_o_sec});
        dnsec     = $signed({1'b0, r_a_nsec}) - $signed({1'b0, r_o_nsec});
        dnsec_mag = dnsec[DNW-1] ? dwsj_pkg::NSEC_W'(-dnsec)
                                 : dwsj_pkg::NSEC_W'(dnsec);

        // truncation toward zero: divide the magnitude, then restore the sign
        ns_part = $signed(RAW_W'(r_p_ns[PNW-1:dwsj_pkg::NS_SHIFT]));
        if (r_ns_neg) begin
            ns_part = -ns_part;
        end
        raw_delay = RAW_W'(r_p_sec) + ns_part;
        if (raw_delay > RAW_MAX) begin
            sat_delay = RAW_MAX[DW-1:0];
        end else if (raw_delay < RAW_MIN) begin
            sat_delay = RAW_MIN[DW-1:0];
        end else begin
            sat_delay = raw_delay[DW-1:0];
        end

        jdiff   = (DW + 1)'(r_delay) - (DW + 1)'(r_prev);
        sum_mag = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);

        jt   = $signed({2'b00, r_jmag}) - $signed({2'b00, r_jit});
        jadj = jt[JW-1] ? jt + JW'(2 ** dwsj_pkg::JIT_SHIFT - 1) : jt;
        jnew = $signed({2'b00, r_jit}) + (jadj >>> dwsj_pkg::JIT_SHIFT);

        pos_next = (r_pos == PW'(dwsj_pkg::WINDOW - 1)) ? '0 : r_pos + PW'(1);
    end

    // architectural state with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_vld  <= '0;
            r_sum  <= '0;
            r_ssq  <= '0;
            r_prev <= '0;
            r_jit  <= '0;
        end else begin
            if (i_cmd.upd) begin
                r_pos        <= pos_next;
                r_vld[r_pos] <= 1'b1;
                r_sum        <= r_sum + SW'(r_delay) - SW'(r_oldest);
                r_prev       <= r_delay;
            end
            if (i_cmd.acc) begin
                r_ssq <= r_ssq + SSW'(r_d2) - SSW'(r_o2);
                r_jit <= jnew[DW-1:0];
            end
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a_sec  <= i_arrival_sec;
            r_a_nsec <= i_arrival_nsec;
            r_o_sec  <= i_origin_sec;
            r_o_nsec <= i_origin_nsec;
        end
        if (i_cmd.mul) begin
            r_p_sec  <= dsec * $signed(dwsj_pkg::US_W'(dwsj_pkg::US_PER_SEC));
            r_p_ns   <= PNW'(dnsec_mag) * PNW'(dwsj_pkg::NS_RECIP);
            r_ns_neg <= dnsec[DNW-1];
            r_oldest <= r_vld[r_pos] ? ram_rdata : '0;
        end
        if (i_cmd.dly) begin
            r_delay <= sat_delay;
        end
        if (i_cmd.upd) begin
            r_d2   <= QW'(r_delay * r_delay);
            r_o2   <= QW'(r_oldest * r_oldest);
            r_jmag <= jdiff[DW] ? DW'(-jdiff) : DW'(jdiff);
        end
        if (i_cmd.acc) begin
            r_abs_sum <= sum_mag;
            r_sum_neg <= r_sum[SW-1];
            r_pp_hh   <= sum_mag[SW-1:HL] * sum_mag[SW-1:HL];
            r_pp_hl   <= sum_mag[SW-1:HL] * sum_mag[HL-1:0];
            r_pp_ll   <= sum_mag[HL-1:0] * sum_mag[HL-1:0];
        end
        if (i_cmd.sq) begin
            r_sq <= (XW'(r_pp_hh) << (2 * HL)) + (XW'(r_pp_hl) << (HL + 1))
                  + XW'(r_pp_ll);
        end
        if (i_cmd.div_take) begin
            unique case (i_cmd.op)
                dwsj_pkg::OP_MEAN: begin
                    r_mean <= r_sum_neg ? DW'(-div_quo[DW-1:0]) : div_quo[DW-1:0];
                end
                dwsj_pkg::OP_CORR: begin
                    r_var_num <= r_ssq - div_quo[SSW-1:0];
                end
                dwsj_pkg::OP_VAR: begin
                    r_var <= (|div_quo[XW-1:VW]) ? '1 : div_quo[VW-1:0];
                end
                default: begin
                    r_var <= r_var;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_delay <= r_delay;
            r_out_mean  <= r_mean;
            r_out_var   <= r_var;
            r_out_jit   <= r_jit;
        end
    end

    assign o_delay_us    = r_out_delay;
    assign o_mean_us     = r_out_mean;
    assign o_variance_us = r_out_var;
    assign o_jitter_us   = r_out_jit;

`ifndef SYNTH
    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |=> r_vld[$past(r_pos)])
        else $error("written window slot not marked valid");
`endif

endmodule

// ===== sv/dwsj_ctrl.sv =====
// controller: sequences one item through the datapath and the divider passes,
// owns the handshakes; uses dwsj_pkg
`timescale 1ns / 1ps

module dwsj_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output dwsj_pkg::t_cmd  o_cmd,
    input  dwsj_pkg::t_stat i_stat
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MUL      = 4'd1;
    localparam logic [3:0] S_DLY      = 4'd2;
    localparam logic [3:0] S_UPD      = 4'd3;
    localparam logic [3:0] S_ACC      = 4'd4;
    localparam logic [3:0] S_SQ       = 4'd5;
    localparam logic [3:0] S_DIV_GO   = 4'd6;
    localparam logic [3:0] S_DIV_WAIT = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_op, n_op;
    logic       r_out_valid, n_out_valid;
    dwsj_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        cmd     = '0;
        cmd.op  = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_DLY;
            end
            S_DLY: begin
                cmd.dly = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                cmd.upd = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: begin
                cmd.sq  = 1'b1;
                n_op    = dwsj_pkg::OP_MEAN;
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                cmd.div_start = 1'b1;
                n_state       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    cmd.div_take = 1'b1;
                    if (r_op == dwsj_pkg::OP_VAR) begin
                        n_state = S_DONE;
                    end else begin
                        n_op    = (r_op == dwsj_pkg::OP_MEAN) ? dwsj_pkg::OP_CORR
                                                              : dwsj_pkg::OP_VAR;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_DONE: begin
                // hand over to the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= dwsj_pkg::OP_MEAN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

`ifndef SYNTH
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside a wait state");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in flight");

    a_mean_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |=> (r_state == S_DIV_GO && r_op == dwsj_pkg::OP_MEAN))
        else $error("divider passes out of order");
`endif

endmodule

// ===== sv/delay_window_stats_jitter.sv =====
// One-way delay statistics: each item carries an arrival and an origin time
// (seconds plus nanoseconds). The block returns, per item, the saturated
// delay in microseconds, the mean and sample variance over the last 16
// delays (zeros count until the window has filled), and the smoothed
// interarrival jitter J += (|D - Dprev| - J)/16. One item is worked on at a
// time: after acceptance, the delay and running-sum arithmetic runs first,
// then the shared constant divider runs three passes (mean, square
// correction, variance), and then the output register is loaded. The result
// waits in that register, so the next item is taken while it is unread.
// No clearing pass is needed after reset.
// Uses dwsj_pkg, dwsj_ctrl and dwsj_dp.
`timescale 1ns / 1ps

module delay_window_stats_jitter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [dwsj_pkg::SEC_W-1:0]          i_arrival_sec,
    input  logic [dwsj_pkg::NSEC_W-1:0]         i_arrival_nsec,
    input  logic [dwsj_pkg::SEC_W-1:0]          i_origin_sec,
    input  logic [dwsj_pkg::NSEC_W-1:0]         i_origin_nsec,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [dwsj_pkg::DELAY_W-1:0] o_delay_us,
    output logic signed [dwsj_pkg::DELAY_W-1:0] o_mean_us,
    output logic [dwsj_pkg::VAR_W-1:0]          o_variance_us,
    output logic [dwsj_pkg::DELAY_W-1:0]        o_jitter_us
);

    dwsj_pkg::t_cmd  cmd;
    dwsj_pkg::t_stat stat;

    dwsj_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    dwsj_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_arrival_sec  (i_arrival_sec),
        .i_arrival_nsec (i_arrival_nsec),
        .i_origin_sec   (i_origin_sec),
        .i_origin_nsec  (i_origin_nsec),
        .o_delay_us     (o_delay_us),
        .o_mean_us      (o_mean_us),
        .o_variance_us  (o_variance_us),
        .o_jitter_us    (o_jitter_us)
    );

endmodule
